/* rtl/core/crm_pkg.sv */
`default_nettype none
package crm_pkg;

   localparam int KEY_W = 160;

   // status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_RESOLVED  = 3'd3;
   localparam logic [2:0] ST_TOO_DEEP  = 3'd4;

   // operation codes
   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   // register indexes
   localparam logic REG_KEEP  = 1'b0;
   localparam logic REG_DEPTH = 1'b1;

   typedef struct packed {
      logic        op;
      logic [63:0] key_hi;
      logic [63:0] key_mid;
      logic [31:0] key_lo;
      logic [63:0] value_hi;
      logic [63:0] value_mid;
      logic [31:0] value_lo;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] result_hi;
      logic [63:0] result_mid;
      logic [31:0] result_lo;
      logic [4:0]  hops;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture request, start search
      logic probe;       // issue a read at the midpoint
      logic compare;     // evaluate read data, narrow the range
      logic next_round;  // follow replacement as new key
      logic shift_rd;    // read entry below shift pointer
      logic shift_wr;    // write it one place up
      logic put_new;     // write new pair at insertion point
      logic put_dup;     // overwrite replacement of match
      logic set_result;  // build result register
      logic send;        // move finished result to output register
      logic [2:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op;
      logic range_empty;
      logic found;
      logic full;
      logic shift_done;
      logic rounds_done;
   } sts_type;

endpackage
`default_nettype wire

/* rtl/core/crm_datapath.sv */
`default_nettype none
module crm_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire crm_pkg::req_type  req_in,
   input  wire crm_pkg::cmd_type  cmd,
   input  wire logic [4:0]        rounds_max,
   output crm_pkg::sts_type       sts,
   output crm_pkg::rsp_type       rsp_data
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = 2 * crm_pkg::KEY_W;

   // table memory: key in upper half, replacement in lower half
   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, sp_ff, sp_in;
   logic [crm_pkg::KEY_W-1:0] key_ff, key_in, val_ff, val_in;
   logic op_ff, found_ff, found_in;
   logic [4:0] hops_ff, hops_in;
   crm_pkg::rsp_type res_ff, res_in;
   crm_pkg::rsp_type out_ff;

   logic [crm_pkg::KEY_W-1:0] rd_key, rd_val;
   logic [CW:0] mid_sum;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] wr_data;
   logic wr_en;

   assign rd_key = rd_ff[EW-1:crm_pkg::KEY_W];
   assign rd_val = rd_ff[crm_pkg::KEY_W-1:0];
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   // memory read and write address selection
   always_comb begin
      rd_addr = mid_in[AW-1:0];
      if (cmd.shift_rd) begin
         rd_addr = AW'(sp_ff - CW'(1));
      end
      wr_en = cmd.shift_wr | cmd.put_new | cmd.put_dup;
      wr_addr = sp_ff[AW-1:0];
      wr_data = rd_ff;
      if (cmd.put_new) begin
         wr_addr = lo_ff[AW-1:0];
         wr_data = {key_ff, val_ff};
      end else if (cmd.put_dup) begin
         wr_addr = mid_ff[AW-1:0];
         wr_data = {rd_key, val_ff};
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // search, shift and chain state
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      mid_in = mid_ff;
      sp_in = sp_ff;
      key_in = key_ff;
      val_in = val_ff;
      found_in = found_ff;
      hops_in = hops_ff;
      count_in = count_ff;
      res_in = res_ff;
      if (cmd.load) begin
         key_in = {req_in.key_hi, req_in.key_mid, req_in.key_lo};
         val_in = {req_in.value_hi, req_in.value_mid, req_in.value_lo};
         lo_in = '0;
         hi_in = count_ff;
         hops_in = '0;
         found_in = 1'b0;
         sp_in = count_ff;
      end
      if (cmd.probe) begin
         mid_in = mid_sum[CW:1];
      end
      if (cmd.compare) begin
         if (rd_key == key_ff) begin
            found_in = 1'b1;
            hi_in = lo_ff;
         end else if (rd_key < key_ff) begin
            lo_in = mid_ff + CW'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.next_round) begin
         key_in = rd_val;
         hops_in = hops_ff + 5'd1;
         lo_in = '0;
         hi_in = count_ff;
         found_in = 1'b0;
      end
      if (cmd.shift_wr) begin
         sp_in = sp_ff - CW'(1);
      end
      if (cmd.put_new) begin
         count_in = count_ff + CW'(1);
      end
      // too deep counts the hop taken in the same cycle
      if (cmd.set_result) begin
         res_in.status = cmd.status;
         res_in.hops = op_ff ? hops_in : 5'd0;
         {res_in.result_hi, res_in.result_mid, res_in.result_lo} =
            (cmd.status == crm_pkg::ST_RESOLVED) ? key_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      mid_ff <= mid_in;
      sp_ff <= sp_in;
      key_ff <= key_in;
      val_ff <= val_in;
      found_ff <= found_in;
      hops_ff <= hops_in;
      res_ff <= res_in;
      if (cmd.load) begin
         op_ff <= req_in.op;
      end
      if (cmd.send) begin
         out_ff <= res_ff;
      end
   end

   logic [4:0] rounds_eff;
   always_comb begin
      rounds_eff = rounds_max;
      if (rounds_max == 5'd0) rounds_eff = 5'd1;
      if (rounds_max > 5'd16) rounds_eff = 5'd16;
   end

   assign sts.op = op_ff;
   assign sts.range_empty = (lo_ff >= hi_ff);
   assign sts.found = found_ff;
   assign sts.full = (count_ff == CW'(TABLE_DEPTH));
   assign sts.shift_done = (sp_ff == lo_ff);
   assign sts.rounds_done = ((hops_ff + 5'd1) >= rounds_eff);
   assign rsp_data = out_ff;
endmodule
`default_nettype wire

/* rtl/core/crm_ctrl.sv */
`default_nettype none
module crm_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic             keep_dup,
   input  wire crm_pkg::sts_type sts,
   output crm_pkg::cmd_type      cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_SHRD  = 3'd4;
   localparam logic [2:0] S_SHWR  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         // range test: probe or conclude
         S_CHECK: begin
            if (sts.found || sts.range_empty) begin
               if (sts.op == crm_pkg::OP_INSERT) begin
                  if (sts.found) begin
                     cmd.put_dup = !keep_dup;
                     cmd.status = crm_pkg::ST_DUPLICATE;
                     state_in = S_RESP;
                  end else if (sts.full) begin
                     cmd.status = crm_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else if (sts.shift_done) begin
                     cmd.put_new = 1'b1;
                     cmd.status = crm_pkg::ST_INSERTED;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SHRD;
                  end
               end else if (!sts.found) begin
                  cmd.status = crm_pkg::ST_RESOLVED;
                  state_in = S_RESP;
               end else if (sts.rounds_done) begin
                  cmd.status = crm_pkg::ST_TOO_DEEP;
                  cmd.next_round = 1'b1;
                  state_in = S_RESP;
               end else begin
                  cmd.next_round = 1'b1;
               end
               if (state_in == S_RESP) begin
                  cmd.set_result = 1'b1;
               end
            end else begin
               cmd.probe = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in = S_CHECK;
         end
         // move entries up one place
         S_SHRD: begin
            cmd.shift_rd = 1'b1;
            state_in = S_SHWR;
         end
         S_SHWR: begin
            cmd.shift_wr = 1'b1;
            state_in = S_CHECK;
         end
         // hand result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.send = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/core/chained_replacement_map.sv */
`default_nettype none
// Sorted map of 160-bit keys to 160-bit replacements. An insert binary-searches
// the table (each probe passes through the check, read and compare states),
// then shifts every later entry up one place, each through a read state and a
// write state on the single table memory. A resolve runs one binary search per
// chain round, up to 16 rounds. One request is worked at a time; an output
// register holds the last result, so the next request can start while that
// result waits for the receiver.
module chained_replacement_map #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire crm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output crm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [4:0]       csr_wdata
);
   logic       keep_ff;
   logic [4:0] depth_ff;
   crm_pkg::cmd_type cmd;
   crm_pkg::sts_type sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= 1'b1;
         depth_ff <= 5'd5;
      end else if (csr_we) begin
         if (csr_index == crm_pkg::REG_KEEP) keep_ff <= csr_wdata[0];
         else depth_ff <= csr_wdata;
      end
   end

   crm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .keep_dup(keep_ff),
      .sts(sts), .cmd(cmd)
   );

   crm_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .req_in(req_data), .cmd(cmd),
      .rounds_max(depth_ff), .sts(sts), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

/* rtl/core/crm_checker.sv */
`default_nettype none
module crm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire crm_pkg::rsp_type rsp_data
);
   // held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // accepted request is not taken again next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken during work");

   // legal status codes only
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= crm_pkg::ST_TOO_DEEP)
      else $error("bad status");

   // inserts carry no hops
   a_hops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != crm_pkg::ST_RESOLVED &&
      rsp_data.status != crm_pkg::ST_TOO_DEEP |-> rsp_data.hops == 5'd0)
      else $error("hops on insert");
endmodule

bind chained_replacement_map crm_checker u_crm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
`default_nettype none

// remembers expected responses and checks the ones the block returns
class map_scoreboard;
   logic [159:0] orig_key [$];
   logic [159:0] repl_key [$];
   bit           keep_dup;
   logic [4:0]   depth_reg;
   crm_pkg::rsp_type pending [$];
   int           errors;
   int           resolved_cnt;
   int           deep_cnt;
   int           dup_cnt;
   int           full_cnt;

   function void reset_state();
      orig_key.delete();
      repl_key.delete();
      keep_dup  = 1'b1;
      depth_reg = 5'd5;
   endfunction

   // binary search; returns match flag, pos gets match or insertion point
   function bit search(logic [159:0] k, output int pos);
      int lo;
      int hi;
      int m;
      lo = 0;
      hi = orig_key.size();
      while (lo < hi) begin
         m = lo + (hi - lo) / 2;
         if (orig_key[m] == k) begin
            pos = m;
            return 1'b1;
         end
         if (orig_key[m] < k) lo = m + 1;
         else hi = m;
      end
      pos = lo;
      return 1'b0;
   endfunction

   // note an accepted request and queue its expected response
   function void note_request(crm_pkg::req_type r);
      crm_pkg::rsp_type e;
      logic [159:0] k;
      int           pos;
      int           rounds;
      bit           done;
      e = '0;
      k = {r.key_hi, r.key_mid, r.key_lo};
      if (r.op == crm_pkg::OP_INSERT) begin
         if (search(k, pos)) begin
            if (!keep_dup) repl_key[pos] = {r.value_hi, r.value_mid, r.value_lo};
            e.status = crm_pkg::ST_DUPLICATE;
            dup_cnt++;
         end else if (orig_key.size() >= 256) begin
            e.status = crm_pkg::ST_FULL;
            full_cnt++;
         end else begin
            orig_key.insert(pos, k);
            repl_key.insert(pos, {r.value_hi, r.value_mid, r.value_lo});
            e.status = crm_pkg::ST_INSERTED;
         end
      end else begin
         rounds = depth_reg;
         if (rounds < 1) rounds = 1;
         if (rounds > 16) rounds = 16;
         done = 1'b0;
         for (int i = 0; i < rounds && !done; i++) begin
            if (!search(k, pos)) begin
               e.status = crm_pkg::ST_RESOLVED;
               {e.result_hi, e.result_mid, e.result_lo} = k;
               e.hops = 5'(i);
               done = 1'b1;
            end else begin
               k = repl_key[pos];
            end
         end
         if (!done) begin
            e.status = crm_pkg::ST_TOO_DEEP;
            e.hops = 5'(rounds);
            deep_cnt++;
         end else begin
            resolved_cnt++;
         end
      end
      pending.push_back(e);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // compare a response with the oldest expectation
   task check_response(crm_pkg::rsp_type g);
      crm_pkg::rsp_type e;
      if (pending.size() == 0) begin
         report("response with nothing outstanding", '0, '0);
         return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) report("status", 64'(g.status), 64'(e.status));
      if (g.result_hi !== e.result_hi) report("result_hi", g.result_hi, e.result_hi);
      if (g.result_mid !== e.result_mid) report("result_mid", g.result_mid, e.result_mid);
      if (g.result_lo !== e.result_lo) report("result_lo", 64'(g.result_lo), 64'(e.result_lo));
      if (g.hops !== e.hops) report("hops", 64'(g.hops), 64'(e.hops));
   endtask
endclass

module tb;
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   crm_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   crm_pkg::rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = crm_pkg::REG_KEEP;
   logic [4:0] csr_wdata = '0;

   map_scoreboard sb;
   int  cycle_cnt = 0;
   int  sent = 0;
   logic [159:0] used_keys [$];

   chained_replacement_map dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > 3000000) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: stall pattern and check
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         case ((cycle_cnt / 200) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= cycle_cnt[2];
         endcase
      end
   end

   function automatic logic [159:0] rand_key();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   // key likely to hit the table: reuse a previous key sometimes
   function automatic logic [159:0] pick_key();
      if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      return rand_key();
   endfunction

   task automatic send_request(logic opc, logic [159:0] k, logic [159:0] v);
      crm_pkg::req_type r;
      r.op = opc;
      {r.key_hi, r.key_mid, r.key_lo} = k;
      {r.value_hi, r.value_mid, r.value_lo} = v;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      if (opc == crm_pkg::OP_INSERT) used_keys.push_back(k);
      sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [4:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == crm_pkg::REG_KEEP) sb.keep_dup = val[0];
      else sb.depth_reg = val;
   endtask

   // random burst phase; reused keys and values build replacement chains
   task automatic random_phase(int count);
      logic [159:0] k;
      logic [159:0] v;
      int n;
      n = 0;
      while (n < count) begin
         repeat ($urandom_range(1, 12)) begin
            if (n < count) begin
               k = pick_key();
               if ($urandom_range(0, 1) == 0) begin
                  v = ($urandom_range(0, 1) == 0) ? pick_key() : rand_key();
                  send_request(crm_pkg::OP_INSERT, k, v);
               end else begin
                  send_request(crm_pkg::OP_RESOLVE, k, '0);
               end
               n++;
            end
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) go_idle();
      end
   endtask

   initial begin
      logic [159:0] a;
      logic [159:0] b;
      logic [159:0] c;
      sb = new();
      sb.reset_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, chains, duplicates, cycle
      a = '0; b = '1; c = {64'h8000_0000_0000_0000, 64'h1, 32'h8000_0000};
      send_request(crm_pkg::OP_RESOLVE, a, '0);
      send_request(crm_pkg::OP_INSERT, a, b);
      send_request(crm_pkg::OP_INSERT, b, c);
      send_request(crm_pkg::OP_INSERT, c, 160'h5);
      send_request(crm_pkg::OP_RESOLVE, a, '0);
      send_request(crm_pkg::OP_RESOLVE, b, '0);
      send_request(crm_pkg::OP_INSERT, a, c);
      send_request(crm_pkg::OP_RESOLVE, a, '0);
      send_request(crm_pkg::OP_INSERT, 160'h5, a);
      send_request(crm_pkg::OP_RESOLVE, a, '0);
      send_request(crm_pkg::OP_RESOLVE, 160'h5, '0);
      drain();
      write_reg(crm_pkg::REG_KEEP, 5'd0);
      write_reg(crm_pkg::REG_DEPTH, 5'd16);
      send_request(crm_pkg::OP_INSERT, a, c);
      send_request(crm_pkg::OP_RESOLVE, a, '0);
      send_request(crm_pkg::OP_RESOLVE, 160'h7, '0);
      drain();
      write_reg(crm_pkg::REG_DEPTH, 5'd0);
      send_request(crm_pkg::OP_RESOLVE, a, '0);
      send_request(crm_pkg::OP_RESOLVE, 160'h6, '0);
      drain();
      write_reg(crm_pkg::REG_DEPTH, 5'd31);
      send_request(crm_pkg::OP_RESOLVE, a, '0);
      drain();
      write_reg(crm_pkg::REG_DEPTH, 5'd1);
      send_request(crm_pkg::OP_RESOLVE, b, '0);

      // random phases with several settings
      random_phase(150);
      drain();
      write_reg(crm_pkg::REG_KEEP, 5'd1);
      write_reg(crm_pkg::REG_DEPTH, 5'd16);
      random_phase(200);
      drain();
      write_reg(crm_pkg::REG_DEPTH, 5'($urandom_range(2, 8)));
      write_reg(crm_pkg::REG_KEEP, 5'd0);
      // fill the table to capacity with fresh keys
      while (sb.orig_key.size() < 256)
         send_request(crm_pkg::OP_INSERT, rand_key(), pick_key());
      random_phase(300);
      drain();
      write_reg(crm_pkg::REG_DEPTH, 5'd3);
      random_phase(150);

      drain();
      $display("sent %0d requests: %0d resolved, %0d too deep, %0d duplicate, %0d full",
               sent, sb.resolved_cnt, sb.deep_cnt, sb.dup_cnt, sb.full_cnt);
      $display("table held %0d entries at the end", sb.orig_key.size());
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire
